// ===== sv/fixed_block_pool_allocator_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Fixed block pool allocator assertion macros
// Shorthand for the concurrent checks used on the allocator ports.
// ----------------------------------------------------------------------------
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_UNIT_MACROS_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FBPA_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("fbpa check failed");

// Next-cycle implication, checked outside reset.
`define FBPA_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("fbpa check failed");

// Condition that must hold in the cycle after reset is applied.
`define FBPA_ASSERT_AFTER_RESET(lbl, cons) \
   lbl: assert property (@(posedge clock) reset |=> (cons)) \
      else $error("fbpa check failed after reset");

`endif

// ===== sv/fbpa_pkg.sv =====
// ----------------------------------------------------------------------------
// Fixed block pool allocator package
// Shared field widths, operation and status codes, and sequencer types.
// ----------------------------------------------------------------------------
package fbpa_pkg;

   // Field widths fixed by the transaction format.
   localparam int ADDR_W      = 32;
   localparam int SIZE_W      = 16;
   localparam int COUNT_W     = 9;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 48;
   localparam int CSR_INDEX_W = 2;

   // Operation codes of a request.
   typedef enum logic [1:0] {
      FUNC_ALLOC = 2'd0,
      FUNC_FREE  = 2'd1,
      FUNC_INIT  = 2'd2,
      FUNC_NOP   = 2'd3
   } fbpa_func_type;

   // Status codes of a response.
   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_EMPTY    = 2'd1,
      STAT_INVALID  = 2'd2,
      STAT_OVERFLOW = 2'd3
   } fbpa_status_type;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_POOL_BASE   = 2'd0,
      CSR_BLOCK_SIZE  = 2'd1,
      CSR_BLOCK_COUNT = 2'd2
   } fbpa_csr_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_INIT,
      S_READ,
      S_MUL,
      S_DIV,
      S_DONE
   } fbpa_state_type;

   // Operations of the shared arithmetic unit.
   typedef enum logic {
      OP_MUL,
      OP_DIV
   } fbpa_op_type;

   // Command from the sequencer to the arithmetic unit.
   typedef struct packed {
      logic        start;
      fbpa_op_type op;
   } fbpa_arith_cmd_type;

   // Status from the arithmetic unit to the sequencer.
   typedef struct packed {
      logic done;
      logic rem_zero;
   } fbpa_arith_sts_type;

endpackage

// ===== sv/fixed_block_pool_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// Fixed block pool allocator
// LIFO free list of fixed-size blocks with alloc, free and init requests.
// ----------------------------------------------------------------------------
// Usage: a request transaction on req_* carries an operation and, for free,
// the block address. Each request yields exactly one response on rsp_* with
// the allocated address, a status and the free-block count after the request.
// The csr_* channel writes pool base, block size and block count; it is
// always ready. The user must see that it is written only while no request is
// in progress; the block does not enforce this. Requests are handled one at a
// time; req_tready is high only when idle. Alloc reads the free list and forms
// the address with a bit-serial multiply in the shared unit; free checks the
// address with a 32-step restoring divide in the shared unit; init writes one
// free-list entry per cycle; a no-op, a failed alloc, a zero-size free or an
// empty init goes straight to the response. A new request can be accepted at
// the same edge as the previous response is taken. The response sits in an
// output register; a stalled receiver holds it, and the next request is taken
// but its response waits until the slot is free. Reset restores the default
// registers and empties the pool; the free list memory is not cleared, so the
// pool stays empty until an init or a free.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_unit #(
   parameter int MAX_BLOCKS = 256
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // req_tdata fields, low bit up: func[1:0], address[33:2], zero pad.
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [fbpa_pkg::REQ_TDATA_W-1:0]      req_tdata,
   // rsp_tdata fields, low bit up: block_address[31:0], status[33:32],
   // free_blocks[42:34], zero pad.
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [fbpa_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [fbpa_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [fbpa_pkg::ADDR_W-1:0]           csr_data
);
   import fbpa_pkg::*;

   localparam int IDX_W = $clog2(MAX_BLOCKS);
   localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

   fbpa_state_type      state_ff, state_in;
   logic [ADDR_W-1:0]   pool_base_ff, pool_base_in;
   logic [SIZE_W-1:0]   block_size_ff, block_size_in;
   logic [COUNT_W-1:0]  block_count_ff, block_count_in;
   logic [CNT_W-1:0]    free_total_ff, free_total_in;
   fbpa_func_type       func_ff, func_in;
   logic [ADDR_W-1:0]   address_ff, address_in;
   logic [IDX_W-1:0]    init_idx_ff, init_idx_in;
   logic [ADDR_W-1:0]   res_addr_ff, res_addr_in;
   fbpa_status_type     res_status_ff, res_status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]   rsp_addr_ff, rsp_addr_in;
   fbpa_status_type     rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]  rsp_free_ff, rsp_free_in;

   logic [CNT_W-1:0]    live_cnt;
   logic                rsp_slot_free;
   logic                ram_wr_en;
   logic [IDX_W-1:0]    ram_wr_addr;
   logic [IDX_W-1:0]    ram_wr_data;
   logic                ram_rd_en;
   logic [IDX_W-1:0]    ram_rd_addr;
   logic [IDX_W-1:0]    ram_rd_data;
   fbpa_arith_cmd_type  arith_cmd;
   fbpa_arith_sts_type  arith_sts;
   logic [ADDR_W-1:0]   arith_opa;
   logic [ADDR_W-1:0]   arith_result;

   // Free list storage.
   fbpa_ram #(
      .WIDTH (IDX_W),
      .DEPTH (MAX_BLOCKS)
   ) u_free_list (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Shared multiply / divide unit.
   fbpa_arith #(
      .IDX_W (IDX_W)
   ) u_arith (
      .clock  (clock),
      .reset  (reset),
      .cmd    (arith_cmd),
      .opa    (arith_opa),
      .opb    (block_size_ff),
      .opm    (ram_rd_data),
      .sts    (arith_sts),
      .result (arith_result)
   );

   // Block count in effect, saturated at the free list depth.
   always_comb begin
      if (32'(block_count_ff) > 32'(MAX_BLOCKS)) begin
         live_cnt = CNT_W'(MAX_BLOCKS);
      end else begin
         live_cnt = CNT_W'(block_count_ff);
      end
   end

   // Configuration writes.
   assign csr_ready = 1'b1;

   always_comb begin
      pool_base_in   = pool_base_ff;
      block_size_in  = block_size_ff;
      block_count_in = block_count_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_POOL_BASE:   pool_base_in   = csr_data;
            CSR_BLOCK_SIZE:  block_size_in  = csr_data[SIZE_W-1:0];
            CSR_BLOCK_COUNT: block_count_in = csr_data[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   assign rsp_slot_free = !rsp_valid_ff || rsp_tready;
   assign req_tready    = (state_ff == S_IDLE);
   // The multiply starts from the pool base; the divide from the offset.
   assign arith_opa = (state_ff == S_READ) ? pool_base_ff : (address_ff - pool_base_ff);

   // Sequencer: next state, free list access and result staging.
   always_comb begin
      state_in      = state_ff;
      free_total_in = free_total_ff;
      func_in       = func_ff;
      address_in    = address_ff;
      init_idx_in   = init_idx_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      rsp_free_in   = rsp_free_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = init_idx_ff;
      ram_wr_data   = init_idx_ff;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = IDX_W'(free_total_ff - CNT_W'(1));
      arith_cmd     = '{start: 1'b0, op: OP_MUL};
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               func_in    = fbpa_func_type'(req_tdata[1:0]);
               address_in = req_tdata[ADDR_W+1:2];
               state_in   = S_EXEC;
            end
         end
         S_EXEC: begin
            res_addr_in   = '0;
            res_status_in = STAT_OK;
            init_idx_in   = '0;
            state_in      = S_DONE;
            case (func_ff)
               FUNC_ALLOC: begin
                  if (free_total_ff == '0) begin
                     res_status_in = STAT_EMPTY;
                  end else begin
                     ram_rd_en     = 1'b1;
                     free_total_in = free_total_ff - 1'b1;
                     state_in      = S_READ;
                  end
               end
               FUNC_FREE: begin
                  if (block_size_ff == '0) begin
                     res_status_in = STAT_INVALID;
                  end else begin
                     arith_cmd = '{start: 1'b1, op: OP_DIV};
                     state_in  = S_DIV;
                  end
               end
               FUNC_INIT: begin
                  if (block_size_ff != '0 && live_cnt != '0) begin
                     state_in = S_INIT;
                  end
               end
               default: ;
            endcase
         end
         S_INIT: begin
            // One free list entry per cycle, index i at position i.
            ram_wr_en   = 1'b1;
            init_idx_in = init_idx_ff + 1'b1;
            if (init_idx_ff == IDX_W'(live_cnt - CNT_W'(1))) begin
               free_total_in = live_cnt;
               state_in      = S_DONE;
            end
         end
         S_READ: begin
            arith_cmd = '{start: 1'b1, op: OP_MUL};
            state_in  = S_MUL;
         end
         S_MUL: begin
            if (arith_sts.done) begin
               res_addr_in = arith_result;
               state_in    = S_DONE;
            end
         end
         S_DIV: begin
            if (arith_sts.done) begin
               state_in = S_DONE;
               if (!arith_sts.rem_zero || arith_result >= ADDR_W'(live_cnt)) begin
                  res_status_in = STAT_INVALID;
               end else if (free_total_ff >= live_cnt) begin
                  res_status_in = STAT_OVERFLOW;
               end else begin
                  ram_wr_en     = 1'b1;
                  ram_wr_addr   = IDX_W'(free_total_ff);
                  ram_wr_data   = arith_result[IDX_W-1:0];
                  free_total_in = free_total_ff + 1'b1;
               end
            end
         end
         S_DONE: begin
            if (rsp_slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = res_addr_ff;
               rsp_status_in = res_status_ff;
               rsp_free_in   = COUNT_W'(free_total_ff);
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         pool_base_ff   <= '0;
         block_size_ff  <= SIZE_W'(32);
         block_count_ff <= COUNT_W'(256);
         free_total_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         pool_base_ff   <= pool_base_in;
         block_size_ff  <= block_size_in;
         block_count_ff <= block_count_in;
         free_total_ff  <= free_total_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      address_ff    <= address_in;
      init_idx_ff   <= init_idx_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_free_ff   <= rsp_free_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - ADDR_W - 2 - COUNT_W)'(0), rsp_free_ff,
                        rsp_status_ff, rsp_addr_ff};

endmodule

// ===== sv/fbpa_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fbpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/fbpa_arith.sv =====
// ----------------------------------------------------------------------------
// Shared shift-add / shift-subtract unit
// One adder serves a bit-serial multiply (base plus index times block size)
// and a restoring divide (offset by block size), one bit per cycle.
// ----------------------------------------------------------------------------
module fbpa_arith #(
   parameter int IDX_W = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  fbpa_pkg::fbpa_arith_cmd_type     cmd,
   input  logic [fbpa_pkg::ADDR_W-1:0]      opa,
   input  logic [fbpa_pkg::SIZE_W-1:0]      opb,
   input  logic [IDX_W-1:0]                 opm,
   output fbpa_pkg::fbpa_arith_sts_type     sts,
   output logic [fbpa_pkg::ADDR_W-1:0]      result
);
   import fbpa_pkg::*;

   localparam int STEP_W = $clog2(ADDR_W);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   fbpa_op_type         op_ff, op_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [ADDR_W-1:0]   acc_ff, acc_in;
   logic [SIZE_W-1:0]   rem_ff, rem_in;
   logic [ADDR_W-1:0]   mcand_ff, mcand_in;
   logic [IDX_W-1:0]    mplier_ff, mplier_in;
   logic [SIZE_W-1:0]   divisor_ff, divisor_in;

   logic [SIZE_W:0]     trial;
   logic [ADDR_W-1:0]   add_a;
   logic [ADDR_W-1:0]   add_b;
   logic                sub;
   logic [ADDR_W:0]     sum;

   // The single adder; the carry out of a subtract means no borrow.
   always_comb begin
      trial = {rem_ff, acc_ff[ADDR_W-1]};
      if (op_ff == OP_DIV) begin
         add_a = ADDR_W'(trial);
         add_b = ADDR_W'(divisor_ff);
         sub   = 1'b1;
      end else begin
         add_a = acc_ff;
         add_b = mcand_ff;
         sub   = 1'b0;
      end
      sum = {1'b0, add_a} + {1'b0, add_b ^ {ADDR_W{sub}}} + (ADDR_W + 1)'(sub);
   end

   // Step sequencing and operand shifting.
   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      op_in      = op_ff;
      step_in    = step_ff;
      acc_in     = acc_ff;
      rem_in     = rem_ff;
      mcand_in   = mcand_ff;
      mplier_in  = mplier_ff;
      divisor_in = divisor_ff;
      if (cmd.start) begin
         busy_in    = 1'b1;
         op_in      = cmd.op;
         acc_in     = opa;
         rem_in     = '0;
         mcand_in   = ADDR_W'(opb);
         mplier_in  = opm;
         divisor_in = opb;
         step_in    = (cmd.op == OP_MUL) ? STEP_W'(IDX_W - 1) : STEP_W'(ADDR_W - 1);
      end else if (busy_ff) begin
         case (op_ff)
            OP_MUL: begin
               if (mplier_ff[0]) begin
                  acc_in = sum[ADDR_W-1:0];
               end
               mcand_in  = {mcand_ff[ADDR_W-2:0], 1'b0};
               mplier_in = mplier_ff >> 1;
            end
            default: begin
               if (sum[ADDR_W]) begin
                  rem_in = sum[SIZE_W-1:0];
                  acc_in = {acc_ff[ADDR_W-2:0], 1'b1};
               end else begin
                  rem_in = trial[SIZE_W-1:0];
                  acc_in = {acc_ff[ADDR_W-2:0], 1'b0};
               end
            end
         endcase
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         op_ff   <= OP_MUL;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         op_ff   <= op_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      step_ff    <= step_in;
      acc_ff     <= acc_in;
      rem_ff     <= rem_in;
      mcand_ff   <= mcand_in;
      mplier_ff  <= mplier_in;
      divisor_ff <= divisor_in;
   end

   assign sts.done     = done_ff;
   assign sts.rem_zero = (rem_ff == '0);
   assign result       = acc_ff;

endmodule

// ===== sv/fbpa_checker.sv =====
// ----------------------------------------------------------------------------
// Fixed block pool allocator port checker
// Watches the allocator ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
`include "fixed_block_pool_allocator_unit_macros.svh"

module fbpa_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [fbpa_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);
   import fbpa_pkg::*;

   logic [ADDR_W-1:0]  rsp_addr;
   logic [1:0]         rsp_status;
   logic [COUNT_W-1:0] rsp_free;

   assign rsp_addr   = rsp_tdata[ADDR_W-1:0];
   assign rsp_status = rsp_tdata[ADDR_W+1:ADDR_W];
   assign rsp_free   = rsp_tdata[ADDR_W+COUNT_W+1:ADDR_W+2];

   // A stalled response stays offered.
   `FBPA_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid)
   // Only one request is in progress: after a transaction the input closes.
   `FBPA_ASSERT_NEXT(a_one_at_a_time, req_tvalid && req_tready, !req_tready)
   // Any status other than success carries a zero address.
   `FBPA_ASSERT_SAME(a_fail_zero_addr, rsp_tvalid && rsp_status != STAT_OK, rsp_addr == '0)
   // An empty pool reports no free blocks.
   `FBPA_ASSERT_SAME(a_empty_count, rsp_tvalid && rsp_status == STAT_EMPTY, rsp_free == '0)
   // No response is offered right after reset.
   `FBPA_ASSERT_AFTER_RESET(a_reset_quiet, !rsp_tvalid)

endmodule

bind fixed_block_pool_allocator_unit fbpa_checker u_fbpa_checker (.*);

// ===== test/fixed_block_pool_allocator_unit_checker.sv =====
// ----------------------------------------------------------------------------
// Fixed block pool allocator response checker
// Watches the request, response and register channels, keeps its own copy of
// the pool registers and the LIFO free list, and compares every response
// transaction with the prediction made when its request was accepted.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_unit_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   input  logic                                 req_tready,
   // req_tdata fields, low bit up: func, address.
   input  logic [fbpa_pkg::REQ_TDATA_W-1:0]     req_tdata,
   input  logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // rsp_tdata fields, low bit up: block_address, status, free_blocks.
   input  logic [fbpa_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   input  logic                                 csr_valid,
   input  logic                                 csr_ready,
   input  logic [fbpa_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [fbpa_pkg::ADDR_W-1:0]          csr_data,
   output int                                   mismatch_count,
   output int                                   pending_count,
   output int                                   checked_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import fbpa_pkg::*;

   localparam int POOL_DEPTH = 256;

   typedef struct {
      logic [ADDR_W-1:0]  block_address;
      fbpa_status_type    status;
      logic [COUNT_W-1:0] free_blocks;
   } pool_response_type;

   // Pool registers and free list as the block should hold them.
   logic [ADDR_W-1:0]  base_addr;
   logic [SIZE_W-1:0]  block_bytes;
   logic [COUNT_W-1:0] block_total;
   logic [7:0]         free_stack [POOL_DEPTH];
   int unsigned        free_total;

   pool_response_type pending_responses [$];

   // Applies one request to the pool copy and returns the response it causes.
   function automatic pool_response_type predict_pool_response(fbpa_func_type func,
                                                               logic [ADDR_W-1:0] address);
      pool_response_type rsp;
      int unsigned       live;
      int unsigned       idx;
      logic [ADDR_W-1:0] offset;
      rsp.block_address = '0;
      rsp.status = STAT_OK;
      // A count above the free-list depth saturates.
      live = (block_total > POOL_DEPTH) ? POOL_DEPTH : block_total;
      case (func)
         FUNC_ALLOC: begin
            if (free_total == 0) begin
               rsp.status = STAT_EMPTY;
            end else begin
               free_total--;
               idx = free_stack[free_total % POOL_DEPTH];
               rsp.block_address = base_addr + 32'(idx) * 32'(block_bytes);
            end
         end
         FUNC_FREE: begin
            // The offset from the base wraps at the address width.
            offset = address - base_addr;
            if (block_bytes == 0 || offset >= 32'(block_bytes) * 32'(live) ||
                offset % block_bytes != 0) begin
               rsp.status = STAT_INVALID;
            end else if (free_total >= live) begin
               rsp.status = STAT_OVERFLOW;
            end else begin
               free_stack[free_total % POOL_DEPTH] = 8'(offset / block_bytes);
               free_total++;
            end
         end
         FUNC_INIT: begin
            if (block_bytes != 0 && live != 0) begin
               for (int i = 0; i < live; i++) begin
                  free_stack[i] = 8'(i);
               end
               free_total = live;
            end
         end
         default: ;
      endcase
      rsp.free_blocks = 9'(free_total);
      return rsp;
   endfunction

   // Responses are checked before the request of the same edge is predicted.
   always @(posedge clock) begin : monitor
      pool_response_type exp_rsp;
      if (reset) begin
         base_addr = '0;
         block_bytes = 16'd32;
         block_total = 9'd256;
         free_total = 0;
         foreach (free_stack[i]) free_stack[i] = '0;
         pending_responses.delete();
         mismatch_count = 0;
         checked_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_responses.size() == 0) begin
               $error("response transaction %h arrived with none expected", rsp_tdata);
               mismatch_count++;
            end else begin
               exp_rsp = pending_responses.pop_front();
               checked_count++;
               if (rsp_tdata[31:0] !== exp_rsp.block_address) begin
                  $error("block_address: expected %h, actual %h",
                         exp_rsp.block_address, rsp_tdata[31:0]);
                  mismatch_count++;
               end
               if (rsp_tdata[33:32] !== exp_rsp.status) begin
                  $error("status: expected %0d, actual %0d", exp_rsp.status, rsp_tdata[33:32]);
                  mismatch_count++;
               end
               if (rsp_tdata[42:34] !== exp_rsp.free_blocks) begin
                  $error("free_blocks: expected %0d, actual %0d",
                         exp_rsp.free_blocks, rsp_tdata[42:34]);
                  mismatch_count++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_POOL_BASE:   base_addr = csr_data;
               CSR_BLOCK_SIZE:  block_bytes = csr_data[SIZE_W-1:0];
               CSR_BLOCK_COUNT: block_total = csr_data[COUNT_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            pending_responses.push_back(predict_pool_response(fbpa_func_type'(req_tdata[1:0]),
                                                              req_tdata[33:2]));
         end
      end
      pending_count = pending_responses.size();
   end

endmodule

// ===== test/fixed_block_pool_allocator_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Fixed block pool allocator testbench
// Drives alloc, free, init and no-op requests through several pool settings,
// from a short directed sequence at the reset settings to long random runs
// with sender gaps and receiver stalls, and leaves response checking to the
// response checker beside the block.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import fbpa_pkg::*;

   localparam int ITEMS_PER_PHASE = 285;
   localparam int PHASE_TOTAL     = 8;
   localparam int DRAIN_PAUSE_AT  = 120;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   // req_tdata fields, low bit up: func, address, zero pad.
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   // rsp_tdata fields, low bit up: block_address, status, free_blocks, zero pad.
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [ADDR_W-1:0]      csr_data;

   int mismatch_count;
   int pending_count;
   int checked_count;

   // Pool settings in force, used to aim free addresses at real blocks.
   logic [ADDR_W-1:0] cfg_base;
   int unsigned       cfg_size;
   int unsigned       cfg_count;

   int tx_gap_pct;
   int rx_stall_pct;
   int request_total;

   fixed_block_pool_allocator_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   fixed_block_pool_allocator_unit_checker response_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .checked_count  (checked_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // The receiver stalls at random, at the rate of the current phase.
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
   end

   // Sends one request transaction, then idles at random.
   task automatic send_request(fbpa_func_type func, logic [ADDR_W-1:0] address);
      req_tdata <= {6'b0, address, 2'(func)};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      request_total++;
      if ($urandom_range(0, 99) < tx_gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
   endtask

   task automatic drop_request();
      if (req_tvalid) req_tvalid <= 1'b0;
   endtask

   task automatic wait_for_drain();
      while (pending_count != 0) @(negedge clock);
   endtask

   task automatic write_csr(fbpa_csr_type index, logic [ADDR_W-1:0] value);
      csr_index <= index;
      csr_data <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Changes the pool settings once the block has gone idle.
   task automatic set_pool(logic [ADDR_W-1:0] base, int unsigned size, int unsigned count);
      drop_request();
      wait_for_drain();
      repeat (4) @(negedge clock);
      write_csr(CSR_POOL_BASE, base);
      write_csr(CSR_BLOCK_SIZE, 32'(size));
      write_csr(CSR_BLOCK_COUNT, 32'(count));
      cfg_base = base;
      cfg_size = size;
      cfg_count = count;
   endtask

   // Mostly allocs and frees of real blocks, with bad addresses and inits mixed in.
   task automatic send_random_request();
      int unsigned       pick;
      logic [ADDR_W-1:0] block_addr;
      pick = $urandom_range(0, 99);
      block_addr = cfg_base + 32'($urandom_range(0, cfg_count - 1)) * 32'(cfg_size);
      if (pick < 38) begin
         send_request(FUNC_ALLOC, $urandom());
      end else if (pick < 70) begin
         send_request(FUNC_FREE, block_addr);
      end else if (pick < 78) begin
         // Inside a block but off its boundary.
         send_request(FUNC_FREE, block_addr + 32'($urandom_range(1, cfg_size - 1)));
      end else if (pick < 84) begin
         send_request(FUNC_FREE,
                      cfg_base + 32'(cfg_count + $urandom_range(0, 3)) * 32'(cfg_size));
      end else if (pick < 88) begin
         send_request(FUNC_FREE, cfg_base - 32'($urandom_range(1, 4)) * 32'(cfg_size));
      end else if (pick < 92) begin
         send_request(FUNC_FREE, $urandom());
      end else if (pick < 97) begin
         send_request(FUNC_INIT, $urandom());
      end else begin
         send_request(FUNC_NOP, $urandom());
      end
   endtask

   task automatic set_idle_mode(int mode);
      case (mode)
         1: begin tx_gap_pct = 51; rx_stall_pct = 0; end
         2: begin tx_gap_pct = 0; rx_stall_pct = 51; end
         3: begin tx_gap_pct = 24; rx_stall_pct = 24; end
         default: begin tx_gap_pct = 0; rx_stall_pct = 0; end
      endcase
   endtask

   // Run limit, several times the slowest correct run.
   initial begin
      #4_000_000;
      $display("fixed_block_pool_allocator_unit: mismatch");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_valid = 1'b0;
      csr_index = CSR_POOL_BASE;
      csr_data = '0;
      request_total = 0;
      cfg_base = '0;
      cfg_size = 32;
      cfg_count = 256;
      set_idle_mode(0);
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed sequence at the reset settings: empty pool, free before init,
      // full pool, bad addresses, double free and the no-op.
      send_request(FUNC_ALLOC, '0);
      send_request(FUNC_FREE, 32'h0000_0000);
      send_request(FUNC_ALLOC, 32'hFFFF_FFFF);
      send_request(FUNC_ALLOC, '0);
      send_request(FUNC_NOP, 32'hFFFF_FFFF);
      send_request(FUNC_INIT, '0);
      send_request(FUNC_FREE, 32'h0000_0000);
      send_request(FUNC_FREE, 32'h0000_0021);
      send_request(FUNC_FREE, 32'h0000_2000);
      send_request(FUNC_FREE, 32'hFFFF_FFFF);
      send_request(FUNC_ALLOC, '0);
      send_request(FUNC_ALLOC, 32'hFFFF_FFFF);
      send_request(FUNC_FREE, 32'h0000_1FE0);
      send_request(FUNC_FREE, 32'h0000_1FE0);
      send_request(FUNC_FREE, 32'h0000_0000);
      send_request(FUNC_FREE, 32'hFFFF_FFE0);
      send_request(FUNC_INIT, 32'hFFFF_FFFF);
      send_request(FUNC_FREE, 32'h0000_1FE0);
      send_request(FUNC_ALLOC, 32'h5555_AAAA);

      // Random phases, each under its own pool settings and idle pattern.
      for (int phase = 1; phase < PHASE_TOTAL; phase++) begin
         case (phase)
            1: set_pool(32'hFFFF_FF00, 4, 256);
            2: set_pool(32'h0000_1000, 65535, 1);
            3: set_pool(32'hFFFF_FFFF, 65535, 256);
            4: set_pool($urandom(), $urandom_range(4, 64), $urandom_range(1, 8));
            5: set_pool(32'h0000_0000, 32, 256);
            6: set_pool($urandom(), $urandom_range(4, 65535), $urandom_range(1, 256));
            default: set_pool($urandom(), $urandom_range(4, 16), $urandom_range(2, 4));
         endcase
         set_idle_mode(phase % 4);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // Hold off once per phase until every response is back.
            if (n == DRAIN_PAUSE_AT) begin
               drop_request();
               wait_for_drain();
            end
            send_random_request();
         end
      end

      drop_request();
      wait_for_drain();
      repeat (40) @(negedge clock);

      $display("Run covered %0d requests under %0d pool settings; %0d responses checked.",
               request_total, PHASE_TOTAL, checked_count);
      $display("Settings ranged over block sizes 4 to 65535, counts 1 to 256, wrapping bases.");
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("fixed_block_pool_allocator_unit: match");
      end else begin
         $display("fixed_block_pool_allocator_unit: mismatch");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/fbpa_pkg.sv
sv/fbpa_ram.sv
sv/fbpa_arith.sv
sv/fixed_block_pool_allocator_unit.sv
sv/fbpa_checker.sv
test/fixed_block_pool_allocator_unit_checker.sv
test/fixed_block_pool_allocator_unit_tb.sv
